// File: sv/rcdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdm_pkg: shared types and constants of the differential drive mixer
// Holds the register map, the item structs, the controller command format
// and the small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package rcdm_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SIGNAL_TIMEOUT  = 3'd0,
    CFG_DEADBAND        = 3'd1,
    CFG_THROTTLE_EXPO   = 3'd2,
    CFG_STEERING_EXPO   = 3'd3,
    CFG_THROTTLE_RAMP   = 3'd4,
    CFG_BRAKE_RAMP      = 3'd5,
    CFG_STEERING_RAMP   = 3'd6,
    CFG_STEER_GAIN      = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [9:0]  RstSignalTimeout = 10'd300;
  localparam logic [7:0]  RstDeadband      = 8'd60;
  localparam logic [15:0] RstThrottleExpo  = 16'd39322;
  localparam logic [15:0] RstSteeringExpo  = 16'd32768;
  localparam logic [14:0] RstThrottleRamp  = 15'd492;
  localparam logic [14:0] RstBrakeRamp     = 15'd1966;
  localparam logic [14:0] RstSteeringRamp  = 15'd655;
  localparam logic [14:0] RstSteerGain     = 15'd9830;

  // Fixed-point thresholds (Q1.15).
  localparam logic [15:0] ZeroThr  = 16'd983;    // 0.03
  localparam logic [15:0] SteerThr = 16'd1638;   // 0.05
  localparam logic [14:0] MaxTurn  = 15'd24576;  // 0.75

  // Normalization: x = |c| * 32768 / 500 is floor(|c| * NormRecip / 2^15).
  localparam logic [21:0] NormRecip  = 22'd2147484;
  localparam logic [12:0] NormFullUs = 13'd500;
  localparam logic [14:0] NormMax    = 15'd32767;

  localparam logic [13:0] PulseMin = 14'd500;
  localparam logic [13:0] PulseMax = 14'd2500;

  typedef struct packed {
    logic [9:0]  timeout_ms;
    logic [7:0]  deadband_us;
    logic [15:0] thr_expo_w;
    logic [15:0] str_expo_w;
    logic [14:0] accel_step;
    logic [14:0] brake_ramp_step;
    logic [14:0] str_slew_step;
    logic [14:0] turn_gain;
  } cfg_t;

  typedef struct packed {
    logic [11:0] throttle_us;
    logic        throttle_seen;
    logic [9:0]  throttle_age_ms;
    logic [11:0] steering_us;
    logic        steering_seen;
    logic [9:0]  steering_age_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] master_cmd;
    logic [15:0] slave_cmd;
    logic [11:0] master_pulse_us;
    logic [11:0] slave_pulse_us;
    logic        throttle_lost;
  } out_item_t;

  // Datapath operations, one per cycle of the sequence.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_NORM    = 4'd1,
    OP_SQ      = 4'd2,
    OP_CUBE    = 4'd3,
    OP_LIN     = 4'd4,
    OP_EH      = 4'd5,
    OP_EL      = 4'd6,
    OP_RAMP    = 4'd7,
    OP_TURN    = 4'd8,
    OP_INSIDE  = 4'd9,
    OP_PULSE_M = 4'd10,
    OP_PULSE_S = 4'd11
  } op_e;

  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic chan;     // 0: throttle channel, 1: steering channel
    op_e  op;
    logic finish;   // results go to the output register
  } cmd_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Move cur toward tgt by at most stp, never passing it.
  function automatic logic signed [15:0] ramp(input logic signed [15:0] cur,
                                              input logic signed [15:0] tgt,
                                              input logic [14:0] stp);
    logic signed [17:0] c;
    logic signed [17:0] t;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    c  = {{2{cur[15]}}, cur};
    t  = {{2{tgt[15]}}, tgt};
    up = c + $signed({3'b000, stp});
    dn = c - $signed({3'b000, stp});
    if (c < t) begin
      ramp = (up < t) ? up[15:0] : tgt;
    end else if (c > t) begin
      ramp = (dn > t) ? dn[15:0] : tgt;
    end else begin
      ramp = cur;
    end
  endfunction

endpackage

// File: sv/rcdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdm_ctrl: sequencer of the differential drive mixer
// Accepts an item, steps the datapath through its fixed operation list and
// hands the result to the output register when that register is free.
// ----------------------------------------------------------------------------
module rcdm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  output rcdm_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  localparam logic [4:0] LastStep = 5'd16;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.chan    = 1'b0;
    cmd_o.op      = rcdm_pkg::OP_NONE;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        // Six expo steps per channel, throttle first, then the mixing steps.
        cmd_o.chan = (step_q >= 5'd6) && (step_q < 5'd12);
        unique case (step_q)
          5'd0, 5'd6:  cmd_o.op = rcdm_pkg::OP_NORM;
          5'd1, 5'd7:  cmd_o.op = rcdm_pkg::OP_SQ;
          5'd2, 5'd8:  cmd_o.op = rcdm_pkg::OP_CUBE;
          5'd3, 5'd9:  cmd_o.op = rcdm_pkg::OP_LIN;
          5'd4, 5'd10: cmd_o.op = rcdm_pkg::OP_EH;
          5'd5, 5'd11: cmd_o.op = rcdm_pkg::OP_EL;
          5'd12:       cmd_o.op = rcdm_pkg::OP_RAMP;
          5'd13:       cmd_o.op = rcdm_pkg::OP_TURN;
          5'd14:       cmd_o.op = rcdm_pkg::OP_INSIDE;
          5'd15:       cmd_o.op = rcdm_pkg::OP_PULSE_M;
          5'd16:       cmd_o.op = rcdm_pkg::OP_PULSE_S;
          default:     cmd_o.op = rcdm_pkg::OP_NONE;
        endcase
        if (step_q == LastStep) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/rcdm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdm_datapath: arithmetic of the differential drive mixer
// One shared 30x23 multiplier with working registers; each command runs one
// step of normalization, expo, ramp, turn reduction or pulse mapping.
// ----------------------------------------------------------------------------
module rcdm_datapath #(
  parameter int unsigned PULSE_CENTER_US    = 1500,
  parameter int unsigned FORWARD_SPAN_US    = 400,
  parameter int unsigned REVERSE_SPAN_US    = 144,
  parameter int unsigned INVERT_THROTTLE_IN = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcdm_pkg::cmd_t       cmd_i,
  input  rcdm_pkg::cfg_t       cfg_i,
  input  rcdm_pkg::in_item_t   in_i,
  output rcdm_pkg::out_item_t  res_o
);

  localparam logic [13:0] Center = 14'(PULSE_CENTER_US);

  logic [11:0] thr_us_q, thr_us_d, str_us_q, str_us_d;
  logic        thr_ok_q, thr_ok_d, str_ok_q, str_ok_d;
  logic [14:0] a_q, a_d;
  logic        neg_q, neg_d;
  logic [29:0] a2_q, a2_d;
  logic [44:0] a3_q, a3_d;
  logic [61:0] acc_q, acc_d;
  logic signed [15:0] thr_q, thr_d, str_q, str_d;
  logic signed [15:0] tl_q, tl_d, sl_q, sl_d;
  logic        zero_q, zero_d;
  logic [14:0] t_q, t_d;
  logic signed [15:0] mcmd_q, mcmd_d, scmd_q, scmd_d;
  logic [11:0] pm_q, pm_d, ps_q, ps_d;

  logic [11:0] us;
  logic signed [13:0] cen;
  logic [12:0] ac;
  logic [15:0] e;
  logic [29:0] mul_a;
  logic [22:0] mul_b;
  logic [52:0] prod;

  logic [61:0] sum;
  logic [15:0] yv;
  logic [15:0] thr_abs, str_abs, tl_abs;
  logic        centered, brake;
  logic [14:0] tt;
  logic [15:0] inner_cmd;
  logic signed [15:0] pcmd;
  logic [15:0] pabs;
  logic signed [13:0] pval;

  assign us   = cmd_i.chan ? str_us_q : thr_us_q;
  assign cen  = $signed({2'b00, us}) - $signed(Center);
  assign ac   = cen[13] ? 13'(-cen) : 13'(cen);
  assign e    = cmd_i.chan ? cfg_i.str_expo_w : cfg_i.thr_expo_w;
  assign prod = 53'(mul_a) * 53'(mul_b);

  always_comb begin
    thr_us_d  = thr_us_q;
    str_us_d  = str_us_q;
    thr_ok_d  = thr_ok_q;
    str_ok_d  = str_ok_q;
    a_d       = a_q;
    neg_d     = neg_q;
    a2_d      = a2_q;
    a3_d      = a3_q;
    acc_d     = acc_q;
    thr_d     = thr_q;
    str_d     = str_q;
    tl_d      = tl_q;
    sl_d      = sl_q;
    zero_d    = zero_q;
    t_d       = t_q;
    mcmd_d    = mcmd_q;
    scmd_d    = scmd_q;
    pm_d      = pm_q;
    ps_d      = ps_q;
    mul_a     = '0;
    mul_b     = '0;
    sum       = '0;
    yv        = '0;
    thr_abs   = rcdm_pkg::abs16(thr_q);
    str_abs   = rcdm_pkg::abs16(str_q);
    tl_abs    = rcdm_pkg::abs16(tl_q);
    centered  = 1'b0;
    brake     = 1'b0;
    tt        = '0;
    inner_cmd = '0;
    pcmd      = (cmd_i.op == rcdm_pkg::OP_PULSE_S) ? scmd_q : mcmd_q;
    pabs      = rcdm_pkg::abs16(pcmd);
    pval      = '0;

    if (cmd_i.capture) begin
      thr_us_d = in_i.throttle_us;
      str_us_d = in_i.steering_us;
      thr_ok_d = in_i.throttle_seen && (in_i.throttle_age_ms <= cfg_i.timeout_ms);
      str_ok_d = in_i.steering_seen && (in_i.steering_age_ms <= cfg_i.timeout_ms);
    end

    case (cmd_i.op)
      rcdm_pkg::OP_NORM: begin
        mul_a = 30'(rcdm_pkg::NormRecip);
        mul_b = 23'(ac);
        if ((cmd_i.chan && !str_ok_q) || (ac < {5'b0, cfg_i.deadband_us})) begin
          a_d = '0;
        end else if (ac >= rcdm_pkg::NormFullUs) begin
          a_d = rcdm_pkg::NormMax;
        end else begin
          a_d = prod[29:15];
        end
        neg_d = cen[13] ^ (!cmd_i.chan && (INVERT_THROTTLE_IN != 0));
      end
      rcdm_pkg::OP_SQ: begin
        mul_a = 30'(a_q);
        mul_b = 23'(a_q);
        a2_d  = prod[29:0];
      end
      rcdm_pkg::OP_CUBE: begin
        mul_a = a2_q;
        mul_b = 23'(a_q);
        a3_d  = prod[44:0];
      end
      rcdm_pkg::OP_LIN: begin
        mul_a = 30'(17'h10000 - {1'b0, e});
        mul_b = 23'(a_q);
        acc_d = 62'(prod[31:0]) << 30;
      end
      rcdm_pkg::OP_EH: begin
        mul_a = 30'(a3_q[44:23]);
        mul_b = 23'(e);
        acc_d = acc_q + (62'(prod[37:0]) << 23);
      end
      rcdm_pkg::OP_EL: begin
        mul_a = 30'(e);
        mul_b = a3_q[22:0];
        sum   = acc_q + 62'(prod[38:0]);
        yv    = {1'b0, sum[60:46]};
        if (cmd_i.chan) begin
          str_d = neg_q ? $signed(-yv) : $signed(yv);
        end else begin
          thr_d = neg_q ? $signed(-yv) : $signed(yv);
        end
      end
      rcdm_pkg::OP_RAMP: begin
        centered = (thr_abs < rcdm_pkg::ZeroThr) && (str_abs < rcdm_pkg::ZeroThr);
        brake    = (thr_abs < tl_abs) ||
                   ((thr_abs < rcdm_pkg::ZeroThr) && (tl_abs > rcdm_pkg::ZeroThr));
        zero_d   = !thr_ok_q || centered;
        if (!thr_ok_q || centered) begin
          tl_d = '0;
          sl_d = '0;
        end else begin
          tl_d = rcdm_pkg::ramp(tl_q, thr_q,
                                brake ? cfg_i.brake_ramp_step : cfg_i.accel_step);
          sl_d = rcdm_pkg::ramp(sl_q, str_q, cfg_i.str_slew_step);
        end
      end
      rcdm_pkg::OP_TURN: begin
        mul_a = 30'(rcdm_pkg::abs16(sl_q));
        mul_b = 23'(cfg_i.turn_gain);
        tt    = prod[29:15];
        t_d   = (tt > rcdm_pkg::MaxTurn) ? rcdm_pkg::MaxTurn : tt;
      end
      rcdm_pkg::OP_INSIDE: begin
        mul_a     = 30'(tl_abs);
        mul_b     = 23'(16'h8000 - {1'b0, t_q});
        inner_cmd = tl_q[15] ? 16'(-{1'b0, prod[29:15]}) : {1'b0, prod[29:15]};
        if (zero_q) begin
          mcmd_d = '0;
          scmd_d = '0;
        end else if (sl_q > $signed(rcdm_pkg::SteerThr)) begin
          mcmd_d = tl_q;
          scmd_d = $signed(inner_cmd);
        end else if (sl_q < -$signed(rcdm_pkg::SteerThr)) begin
          mcmd_d = $signed(inner_cmd);
          scmd_d = tl_q;
        end else begin
          mcmd_d = tl_q;
          scmd_d = tl_q;
        end
      end
      rcdm_pkg::OP_PULSE_M, rcdm_pkg::OP_PULSE_S: begin
        mul_a = 30'(pabs);
        mul_b = pcmd[15] ? 23'(REVERSE_SPAN_US) : 23'(FORWARD_SPAN_US);
        if (pabs < rcdm_pkg::ZeroThr) begin
          pval = $signed(Center);
        end else if (pcmd[15]) begin
          pval = $signed(Center) - $signed({4'b0, prod[24:15]});
        end else begin
          pval = $signed(Center) + $signed({4'b0, prod[24:15]});
        end
        if (pval < $signed(rcdm_pkg::PulseMin)) begin
          pval = $signed(rcdm_pkg::PulseMin);
        end
        if (pval > $signed(rcdm_pkg::PulseMax)) begin
          pval = $signed(rcdm_pkg::PulseMax);
        end
        if (cmd_i.op == rcdm_pkg::OP_PULSE_S) begin
          ps_d = pval[11:0];
        end else begin
          pm_d = pval[11:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Mixer state: the two slew-limited levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= '0;
      sl_q <= '0;
    end else begin
      tl_q <= tl_d;
      sl_q <= sl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_us_q <= thr_us_d;
    str_us_q <= str_us_d;
    thr_ok_q <= thr_ok_d;
    str_ok_q <= str_ok_d;
    a_q      <= a_d;
    neg_q    <= neg_d;
    a2_q     <= a2_d;
    a3_q     <= a3_d;
    acc_q    <= acc_d;
    thr_q    <= thr_d;
    str_q    <= str_d;
    zero_q   <= zero_d;
    t_q      <= t_d;
    mcmd_q   <= mcmd_d;
    scmd_q   <= scmd_d;
    pm_q     <= pm_d;
    ps_q     <= ps_d;
  end

  assign res_o.master_cmd      = mcmd_q;
  assign res_o.slave_cmd       = scmd_q;
  assign res_o.master_pulse_us = pm_q;
  assign res_o.slave_pulse_us  = ps_q;
  assign res_o.throttle_lost   = !thr_ok_q;

endmodule

// File: sv/rc_differential_drive_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer_unit: RC differential steering mixer
// Turns throttle and steering pulse readings into two wheel commands and
// two PPM pulse widths, with expo shaping, slew limiting and a stop on loss.
// ----------------------------------------------------------------------------
// Usage: one transaction on the s_axis side carries one control tick's
// throttle and steering readings; one transaction on the m_axis side returns
// the two wheel commands, the two pulse widths and the throttle lost flag.
// Every input transaction gives exactly one output transaction, in order.
// From its acceptance, an item makes one 17-step pass through a single
// shared 30x23 multiplier (six steps of expo per channel, then ramp, turn,
// inside wheel and two pulse mappings), and its result is then loaded into
// the output register. A new item is accepted once the previous one has
// left the sequencer, so no two items are computed at once.
// The result sits in an output register; the next item is accepted and
// computed while it waits. If the receiver stalls, the finished next result
// is held inside until the output register frees up, and no further input
// is accepted meanwhile.
// Reset clears both slew levels to zero, loads the configuration registers
// with their defaults and empties the output register. Configuration is
// written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user must write
// it only while the block is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer_unit #(
  parameter int unsigned PULSE_CENTER_US    = 1500,
  parameter int unsigned FORWARD_SPAN_US    = 400,
  parameter int unsigned REVERSE_SPAN_US    = 144,
  parameter int unsigned INVERT_THROTTLE_IN = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: throttle_us[12], throttle_seen, throttle_age_ms[10],
  // steering_us[12], steering_seen, steering_age_ms[10], two zero bits.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: master_cmd[16], slave_cmd[16], master_pulse_us[12],
  // slave_pulse_us[12], throttle_lost, seven zero bits.
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [rcdm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  rcdm_pkg::cfg_t      cfg_q, cfg_d;
  rcdm_pkg::in_item_t  in_item;
  rcdm_pkg::out_item_t res;
  rcdm_pkg::cmd_t      cmd;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         out_data_q, out_data_d;
  logic                out_free;

  // Configuration registers; each write replaces one register with the low bits of cfg_wdata_i.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rcdm_pkg::cfg_idx_e'(cfg_index_i))
        rcdm_pkg::CFG_SIGNAL_TIMEOUT: cfg_d.timeout_ms      = cfg_wdata_i[9:0];
        rcdm_pkg::CFG_DEADBAND:       cfg_d.deadband_us     = cfg_wdata_i[7:0];
        rcdm_pkg::CFG_THROTTLE_EXPO:  cfg_d.thr_expo_w      = cfg_wdata_i;
        rcdm_pkg::CFG_STEERING_EXPO:  cfg_d.str_expo_w      = cfg_wdata_i;
        rcdm_pkg::CFG_THROTTLE_RAMP:  cfg_d.accel_step      = cfg_wdata_i[14:0];
        rcdm_pkg::CFG_BRAKE_RAMP:     cfg_d.brake_ramp_step = cfg_wdata_i[14:0];
        rcdm_pkg::CFG_STEERING_RAMP:  cfg_d.str_slew_step   = cfg_wdata_i[14:0];
        rcdm_pkg::CFG_STEER_GAIN:     cfg_d.turn_gain       = cfg_wdata_i[14:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms      <= rcdm_pkg::RstSignalTimeout;
      cfg_q.deadband_us     <= rcdm_pkg::RstDeadband;
      cfg_q.thr_expo_w      <= rcdm_pkg::RstThrottleExpo;
      cfg_q.str_expo_w      <= rcdm_pkg::RstSteeringExpo;
      cfg_q.accel_step      <= rcdm_pkg::RstThrottleRamp;
      cfg_q.brake_ramp_step <= rcdm_pkg::RstBrakeRamp;
      cfg_q.str_slew_step   <= rcdm_pkg::RstSteeringRamp;
      cfg_q.turn_gain       <= rcdm_pkg::RstSteerGain;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the input transaction.
  assign in_item.throttle_us     = s_axis_tdata[11:0];
  assign in_item.throttle_seen   = s_axis_tdata[12];
  assign in_item.throttle_age_ms = s_axis_tdata[22:13];
  assign in_item.steering_us     = s_axis_tdata[34:23];
  assign in_item.steering_seen   = s_axis_tdata[35];
  assign in_item.steering_age_ms = s_axis_tdata[45:36];

  // The output register may take a new result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;

  rcdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  rcdm_datapath #(
    .PULSE_CENTER_US    (PULSE_CENTER_US),
    .FORWARD_SPAN_US    (FORWARD_SPAN_US),
    .REVERSE_SPAN_US    (REVERSE_SPAN_US),
    .INVERT_THROTTLE_IN (INVERT_THROTTLE_IN)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .in_i   (in_item),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd.finish) begin
      out_valid_d = 1'b1;
      out_data_d  = {7'b0, res.throttle_lost, res.slave_pulse_us, res.master_pulse_us,
                     res.slave_cmd, res.master_cmd};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/rcdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdm_checker: port-level checks of the differential drive mixer
// Watches the result channel for stop behavior, zero-command centering, pulse range and stall hold.
// ----------------------------------------------------------------------------
module rcdm_checker #(
  parameter int unsigned PULSE_CENTER_US = 1500
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  localparam logic [11:0] Center = 12'(PULSE_CENTER_US);

  // A lost throttle forces zero commands and centered pulses.
  a_lost_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[56] |->
      m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[31:16] == 16'd0 &&
      m_axis_tdata[43:32] == Center && m_axis_tdata[55:44] == Center)
    else $error("lost throttle did not stop both wheels");

  // Zero commands on both wheels always map to center pulses.
  a_zero_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[31:16] == 16'd0 |->
      m_axis_tdata[43:32] == Center && m_axis_tdata[55:44] == Center)
    else $error("zero command without center pulse");

  // Pulses stay inside the clamp window.
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[43:32] >= 12'd500 && m_axis_tdata[43:32] <= 12'd2500 &&
      m_axis_tdata[55:44] >= 12'd500 && m_axis_tdata[55:44] <= 12'd2500)
    else $error("pulse width out of range");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind rc_differential_drive_mixer_unit rcdm_checker #(
  .PULSE_CENTER_US (PULSE_CENTER_US)
) u_rcdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
